>>> design/bpu_pkg.sv
// ----------------------------------------------------------------------------
// bpu_pkg
// types, codes and constants shared by the bitmap pixel stream unpacker
// ----------------------------------------------------------------------------
package bpu_pkg;

	localparam int MAX_WIDTH_DEF     = 4096;
	localparam int PALETTE_DEPTH_DEF = 256;
	localparam int MAX_HEIGHT        = 4096;
	localparam int QUEUE_DEPTH       = 2;

	localparam int CFG_INDEX_W = 3;

	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_FORMAT  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_BITFIELD_MODE = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_RED_MASK      = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_GREEN_MASK    = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_BLUE_MASK     = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_MASK    = 3'd7;

	localparam logic [1:0] FMT_PAL8  = 2'd0;
	localparam logic [1:0] FMT_RGB24 = 2'd1;
	localparam logic [1:0] FMT_RGB32 = 2'd2;

	localparam logic FUNC_PALETTE = 1'b0;
	localparam logic FUNC_PIXEL   = 1'b1;

	localparam logic [31:0] MASK_BYTE3 = 32'hFF000000;
	localparam logic [31:0] MASK_BYTE2 = 32'h00FF0000;
	localparam logic [31:0] MASK_BYTE1 = 32'h0000FF00;
	localparam logic [31:0] MASK_BYTE0 = 32'h000000FF;

	typedef struct packed {
		logic        func;
		logic [7:0]  palette_index;
		logic [31:0] palette_word;
		logic [7:0]  data_byte;
	} req_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       row_end;
		logic       image_end;
	} pix_t;

	typedef struct packed {
		logic [12:0] image_width;
		logic [12:0] image_height;
		logic [1:0]  pixel_format;
		logic        bitfield_mode;
	} geom_t;

	typedef struct packed {
		logic [31:0] red_mask;
		logic [31:0] green_mask;
		logic [31:0] blue_mask;
		logic [31:0] alpha_mask;
	} mask_t;

	typedef enum logic [2:0] {
		OP_PAL_WRITE,
		OP_PAL_PIXEL,
		OP_PLAIN24,
		OP_PLAIN32,
		OP_BITFIELD
	} op_kind_t;

	typedef struct packed {
		op_kind_t    kind;
		logic        zero;
		logic        row_end;
		logic        image_end;
		logic [7:0]  idx;
		logic [31:0] word;
	} op_t;

endpackage

>>> design/bpu_ram.sv
// ----------------------------------------------------------------------------
// bpu_ram
// generic ram, one write port and one read port with registered read data
// ----------------------------------------------------------------------------
module bpu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> design/bpu_front.sv
// ----------------------------------------------------------------------------
// bpu_front
// request intake: byte gathering, padding skip, row and column counting
// ----------------------------------------------------------------------------
module bpu_front #(
	parameter int MAX_WIDTH     = bpu_pkg::MAX_WIDTH_DEF,
	parameter int PALETTE_DEPTH = bpu_pkg::PALETTE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           clear,
	input  bpu_pkg::geom_t geom,
	input  logic           req_valid,
	output logic           req_stall,
	input  bpu_pkg::req_t  req_data,
	input  logic           q_full,
	output logic           push,
	output bpu_pkg::op_t   push_op
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = (CW + 1 > 13) ? CW + 1 : 13;
	localparam logic [WW-1:0] MAXW = WW'(MAX_WIDTH);
	localparam logic [12:0] MAXH = 13'(bpu_pkg::MAX_HEIGHT);

	logic [23:0]   gather_q;
	logic [1:0]    pos_q;
	logic [CW-1:0] col_q;
	logic [11:0]   row_q;
	logic [1:0]    pad_q;

	logic [WW-1:0] w_raw;
	logic [WW-1:0] w_cl;
	logic [12:0]   h_cl;
	logic          last_col;
	logic          last_row;
	logic          accept;
	logic          is_pal;
	logic          is_bitf;
	logic          is_four;
	logic          last_byte;
	logic          idx_ok;
	logic          pix_done;
	logic [1:0]    w3;
	logic [1:0]    pad_next;
	logic [31:0]   word;

	assign req_stall = q_full;
	assign accept    = req_valid && !q_full;

	assign w_raw = WW'(geom.image_width);
	assign w_cl  = (w_raw == '0) ? WW'(1) : ((w_raw > MAXW) ? MAXW : w_raw);
	assign h_cl  = (geom.image_height == 13'd0) ? 13'd1 :
		((geom.image_height > MAXH) ? MAXH : geom.image_height);

	assign last_col = (WW'(col_q) + WW'(1)) >= w_cl;
	assign last_row = (13'(row_q) + 13'd1) >= h_cl;

	assign is_pal    = geom.pixel_format == bpu_pkg::FMT_PAL8;
	assign is_bitf   = !is_pal && geom.bitfield_mode;
	assign is_four   = !is_pal && (is_bitf || geom.pixel_format != bpu_pkg::FMT_RGB24);
	assign last_byte = is_pal || (is_four ? (pos_q == 2'd3) : (pos_q == 2'd2));

	assign idx_ok = 9'(req_data.palette_index) < 9'(PALETTE_DEPTH);

	assign pix_done = req_data.func == bpu_pkg::FUNC_PIXEL && pad_q == 2'd0 && last_byte;

	assign w3 = w_cl[1:0] + {w_cl[0], 1'b0};

	always_comb begin
		if (is_pal) begin
			pad_next = 2'd0 - w_cl[1:0];
		end else if (is_four) begin
			pad_next = 2'd0;
		end else begin
			pad_next = 2'd0 - w3;
		end
	end

	assign word = {8'd0, gather_q} | (32'(req_data.data_byte) << {pos_q, 3'b000});

	always_comb begin
		push_op           = '0;
		push_op.row_end   = last_col;
		push_op.image_end = last_col && last_row;
		if (req_data.func == bpu_pkg::FUNC_PALETTE) begin
			push_op.kind = bpu_pkg::OP_PAL_WRITE;
			push_op.idx  = req_data.palette_index;
			push_op.word = req_data.palette_word;
		end else if (is_pal) begin
			push_op.kind = bpu_pkg::OP_PAL_PIXEL;
			push_op.idx  = req_data.data_byte;
			push_op.zero = 9'(req_data.data_byte) >= 9'(PALETTE_DEPTH);
		end else if (is_bitf) begin
			push_op.kind = bpu_pkg::OP_BITFIELD;
			push_op.word = word;
		end else if (is_four) begin
			push_op.kind = bpu_pkg::OP_PLAIN32;
			push_op.word = word;
		end else begin
			push_op.kind = bpu_pkg::OP_PLAIN24;
			push_op.word = word;
		end
	end

	assign push = accept && ((req_data.func == bpu_pkg::FUNC_PALETTE && idx_ok) || pix_done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gather_q <= '0;
			pos_q    <= '0;
			col_q    <= '0;
			row_q    <= '0;
			pad_q    <= '0;
		end else if (clear) begin
			gather_q <= '0;
			pos_q    <= '0;
			col_q    <= '0;
			row_q    <= '0;
			pad_q    <= '0;
		end else if (accept && req_data.func == bpu_pkg::FUNC_PIXEL) begin
			if (pad_q != 2'd0) begin
				pad_q <= pad_q - 2'd1;
			end else if (!last_byte) begin
				pos_q <= pos_q + 2'd1;
				case (pos_q)
					2'd0: begin
						gather_q[7:0] <= req_data.data_byte;
					end
					2'd1: begin
						gather_q[15:8] <= req_data.data_byte;
					end
					default: begin
						gather_q[23:16] <= req_data.data_byte;
					end
				endcase
			end else begin
				gather_q <= '0;
				pos_q    <= '0;
				if (last_col) begin
					col_q <= '0;
					pad_q <= pad_next;
					row_q <= last_row ? '0 : row_q + 12'd1;
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

endmodule

>>> design/bpu_queue.sv
// ----------------------------------------------------------------------------
// bpu_queue
// short fifo of classified requests between the front and the back
// ----------------------------------------------------------------------------
module bpu_queue (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  bpu_pkg::op_t push_op,
	output logic         full,
	input  logic         pop,
	output logic         valid,
	output bpu_pkg::op_t head
);

	localparam int D  = bpu_pkg::QUEUE_DEPTH;
	localparam int PW = (D > 1) ? $clog2(D) : 1;
	localparam int NW = $clog2(D + 1);

	bpu_pkg::op_t  ent_q [D];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;

	assign full  = count_q == NW'(D);
	assign valid = count_q != '0;
	assign head  = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(D - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(D - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

endmodule

>>> design/bpu_back.sv
// ----------------------------------------------------------------------------
// bpu_back
// palette store, channel extraction and output register
// ----------------------------------------------------------------------------
module bpu_back #(
	parameter int PALETTE_DEPTH = bpu_pkg::PALETTE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  bpu_pkg::mask_t masks,
	input  logic           q_valid,
	input  bpu_pkg::op_t   head,
	output logic           pop,
	output logic           pix_valid,
	input  logic           pix_stall,
	output bpu_pkg::pix_t  pix_data
);

	localparam int AW = $clog2(PALETTE_DEPTH);

	logic          s1_v_q;
	bpu_pkg::op_t  op_s1;
	logic          out_v_q;
	bpu_pkg::pix_t out_q;
	logic          out_ready;
	logic          s1_ready;
	logic          ram_we;
	logic          ram_re;
	logic [31:0]   ram_rdata;
	logic [31:0]   pw;
	bpu_pkg::pix_t pix_next;

	function automatic logic [7:0] mask_channel(input logic [31:0] w, input logic [31:0] m);
		logic [7:0] c;
		if (m == bpu_pkg::MASK_BYTE3) begin
			c = w[31:24];
		end else if (m == bpu_pkg::MASK_BYTE2) begin
			c = w[23:16];
		end else if (m == bpu_pkg::MASK_BYTE1) begin
			c = w[15:8];
		end else if (m == bpu_pkg::MASK_BYTE0) begin
			c = w[7:0];
		end else begin
			c = 8'hFF;
		end
		return c;
	endfunction

	assign out_ready = !out_v_q || !pix_stall;
	assign s1_ready  = !s1_v_q || out_ready;
	assign pop       = q_valid && s1_ready;
	assign ram_we    = pop && head.kind == bpu_pkg::OP_PAL_WRITE;
	assign ram_re    = pop && head.kind != bpu_pkg::OP_PAL_WRITE;

	bpu_ram #(
		.WIDTH(32),
		.DEPTH(PALETTE_DEPTH)
	) u_palette (
		.clk  (clk),
		.we   (ram_we),
		.waddr(head.idx[AW-1:0]),
		.wdata(head.word),
		.re   (ram_re),
		.raddr(head.idx[AW-1:0]),
		.rdata(ram_rdata)
	);

	assign pw = op_s1.zero ? 32'd0 : ram_rdata;

	always_comb begin
		pix_next           = '0;
		pix_next.row_end   = op_s1.row_end;
		pix_next.image_end = op_s1.image_end;
		case (op_s1.kind)
			bpu_pkg::OP_PAL_PIXEL: begin
				pix_next.blue  = pw[7:0];
				pix_next.green = pw[15:8];
				pix_next.red   = pw[23:16];
				pix_next.alpha = pw[31:24];
			end
			bpu_pkg::OP_BITFIELD: begin
				pix_next.red   = mask_channel(op_s1.word, masks.red_mask);
				pix_next.green = mask_channel(op_s1.word, masks.green_mask);
				pix_next.blue  = mask_channel(op_s1.word, masks.blue_mask);
				pix_next.alpha = mask_channel(op_s1.word, masks.alpha_mask);
			end
			bpu_pkg::OP_PLAIN32: begin
				pix_next.blue  = op_s1.word[7:0];
				pix_next.green = op_s1.word[15:8];
				pix_next.red   = op_s1.word[23:16];
				pix_next.alpha = op_s1.word[31:24];
			end
			bpu_pkg::OP_PLAIN24: begin
				pix_next.blue  = op_s1.word[7:0];
				pix_next.green = op_s1.word[15:8];
				pix_next.red   = op_s1.word[23:16];
			end
			default: begin
				pix_next.red = 8'd0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			op_s1 <= head;
		end
		if (out_ready && s1_v_q) begin
			out_q <= pix_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s1_ready) begin
				s1_v_q <= ram_re;
			end
			if (out_ready) begin
				out_v_q <= s1_v_q;
			end
		end
	end

	assign pix_valid = out_v_q;
	assign pix_data  = out_q;

endmodule

>>> design/bmp_pixel_stream_unpacker.sv
// ----------------------------------------------------------------------------
// bmp_pixel_stream_unpacker
// unpacks a bitmap pixel array, one byte per request, into rgba pixels
// ----------------------------------------------------------------------------
// requests come in on req (valid/stall): func 0 writes a palette word,
// func 1 carries the next byte of the pixel array. pixels leave on pix
// (valid/stall) with row_end and image_end marks. registers are written on
// cfg (valid/ready, always ready); the user must write them only while the
// block is idle, which the block does not enforce. any write restarts the
// stream position at the first byte of an image. throughput is one request
// per cycle while req is not stalled. a finished pixel passes through the
// request queue, the registered palette read and the output register in the
// back end. padding bytes and partial pixel bytes produce no output.
// a stall on pix holds the output register; the back end then stops popping
// and the two-entry queue fills, after which req is stalled.
// reset clears the stream position and sets 1x1 pixels, 24-bit format. the
// palette is not cleared; an entry must be written before it is used.
// ----------------------------------------------------------------------------
module bmp_pixel_stream_unpacker #(
	parameter int MAX_WIDTH     = bpu_pkg::MAX_WIDTH_DEF,
	parameter int PALETTE_DEPTH = bpu_pkg::PALETTE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  bpu_pkg::req_t                   req_data,
	output logic                            pix_valid,
	input  logic                            pix_stall,
	output bpu_pkg::pix_t                   pix_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bpu_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]                     cfg_data
);

	bpu_pkg::geom_t geom_q;
	bpu_pkg::mask_t mask_q;
	logic           cfg_wr;
	logic           push;
	bpu_pkg::op_t   push_op;
	logic           q_full;
	logic           q_valid;
	logic           pop;
	bpu_pkg::op_t   head;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_q.image_width   <= 13'd1;
			geom_q.image_height  <= 13'd1;
			geom_q.pixel_format  <= bpu_pkg::FMT_RGB24;
			geom_q.bitfield_mode <= 1'b0;
			mask_q               <= '0;
		end else if (cfg_wr) begin
			case (cfg_index)
				bpu_pkg::REG_IMAGE_WIDTH: begin
					geom_q.image_width <= cfg_data[12:0];
				end
				bpu_pkg::REG_IMAGE_HEIGHT: begin
					geom_q.image_height <= cfg_data[12:0];
				end
				bpu_pkg::REG_PIXEL_FORMAT: begin
					geom_q.pixel_format <= cfg_data[1:0];
				end
				bpu_pkg::REG_BITFIELD_MODE: begin
					geom_q.bitfield_mode <= cfg_data[0];
				end
				bpu_pkg::REG_RED_MASK: begin
					mask_q.red_mask <= cfg_data;
				end
				bpu_pkg::REG_GREEN_MASK: begin
					mask_q.green_mask <= cfg_data;
				end
				bpu_pkg::REG_BLUE_MASK: begin
					mask_q.blue_mask <= cfg_data;
				end
				bpu_pkg::REG_ALPHA_MASK: begin
					mask_q.alpha_mask <= cfg_data;
				end
				default: begin
					mask_q.alpha_mask <= cfg_data;
				end
			endcase
		end
	end

	bpu_front #(
		.MAX_WIDTH    (MAX_WIDTH),
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (cfg_wr),
		.geom     (geom_q),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data (req_data),
		.q_full   (q_full),
		.push     (push),
		.push_op  (push_op)
	);

	bpu_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.push_op(push_op),
		.full   (q_full),
		.pop    (pop),
		.valid  (q_valid),
		.head   (head)
	);

	bpu_back #(
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.masks    (mask_q),
		.q_valid  (q_valid),
		.head     (head),
		.pop      (pop),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix_data (pix_data)
	);

endmodule

>>> verif/bpu_pixel_checker.sv
// ----------------------------------------------------------------------------
// bpu_pixel_checker
// watches the request, pixel and register channels of the bitmap pixel
// stream unpacker, predicts every pixel from the accepted requests and
// compares it field by field with what the block delivers
// ----------------------------------------------------------------------------
module bpu_pixel_checker
	import bpu_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	input  logic                   req_stall,
	input  req_t                   req_data,
	input  logic                   pix_valid,
	input  logic                   pix_stall,
	input  pix_t                   pix_data,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]            cfg_data,
	output int                     fail_count,
	output int                     pending
);
	timeunit 1ns;
	timeprecision 1ps;

	geom_t       geom;
	mask_t       chan_masks;
	logic [31:0] palette_mem [PALETTE_DEPTH_DEF];
	logic [23:0] gather_bits;
	int          gather_pos;
	int          column;
	int          row;
	int          pad_left;
	int          pixel_number;
	pix_t        expected_pixels [$];
	pix_t        want;
	pix_t        made_pixel;
	bit          made;

	task automatic report_mismatch(input string msg);
		$display("%0t: pixel %0d: %s", $realtime, pixel_number, msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic [7:0] got,
			input logic [7:0] want_val);
		if (got !== want_val)
			report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want_val));
	endtask

	function automatic logic [7:0] mask_field(input logic [31:0] word,
			input logic [31:0] mask);
		case (mask)
			MASK_BYTE3: return word[31:24];
			MASK_BYTE2: return word[23:16];
			MASK_BYTE1: return word[15:8];
			MASK_BYTE0: return word[7:0];
			default:    return 8'hFF;
		endcase
	endfunction

	task automatic clear_position();
		gather_bits = '0;
		gather_pos  = 0;
		column      = 0;
		row         = 0;
		pad_left    = 0;
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
			input logic [31:0] value);
		case (idx)
			REG_IMAGE_WIDTH:   geom.image_width   = value[12:0];
			REG_IMAGE_HEIGHT:  geom.image_height  = value[12:0];
			REG_PIXEL_FORMAT:  geom.pixel_format  = value[1:0];
			REG_BITFIELD_MODE: geom.bitfield_mode = value[0];
			REG_RED_MASK:      chan_masks.red_mask   = value;
			REG_GREEN_MASK:    chan_masks.green_mask = value;
			REG_BLUE_MASK:     chan_masks.blue_mask  = value;
			REG_ALPHA_MASK:    chan_masks.alpha_mask = value;
			default: ;
		endcase
		clear_position();
	endtask

	task automatic unpack_byte(input req_t r, output bit made_one, output pix_t px);
		int          w;
		int          h;
		int          bpp;
		bit          use_masks;
		logic [31:0] word;
		logic [31:0] entry;
		made_one = 1'b0;
		px = '0;
		w = int'(geom.image_width);
		h = int'(geom.image_height);
		if (w == 0)
			w = 1;
		else if (w > MAX_WIDTH_DEF)
			w = MAX_WIDTH_DEF;
		if (h == 0)
			h = 1;
		else if (h > MAX_HEIGHT)
			h = MAX_HEIGHT;
		use_masks = (geom.pixel_format != FMT_PAL8) && geom.bitfield_mode;
		if (geom.pixel_format == FMT_PAL8)
			bpp = 1;
		else if (use_masks || geom.pixel_format != FMT_RGB24)
			bpp = 4;
		else
			bpp = 3;

		if (r.func == FUNC_PALETTE) begin
			palette_mem[r.palette_index] = r.palette_word;
		end else if (pad_left != 0) begin
			pad_left--;
		end else if (gather_pos + 1 < bpp) begin
			gather_bits = gather_bits | ({16'h0, r.data_byte} << (8 * gather_pos));
			gather_pos++;
		end else begin
			word = {8'h00, gather_bits} | ({24'h0, r.data_byte} << (8 * gather_pos));
			if (bpp == 1) begin
				entry    = palette_mem[r.data_byte];
				px.blue  = entry[7:0];
				px.green = entry[15:8];
				px.red   = entry[23:16];
				px.alpha = entry[31:24];
			end else if (use_masks) begin
				px.red   = mask_field(word, chan_masks.red_mask);
				px.green = mask_field(word, chan_masks.green_mask);
				px.blue  = mask_field(word, chan_masks.blue_mask);
				px.alpha = mask_field(word, chan_masks.alpha_mask);
			end else begin
				px.blue  = word[7:0];
				px.green = word[15:8];
				px.red   = word[23:16];
				px.alpha = (bpp == 4) ? word[31:24] : 8'h00;
			end
			gather_bits = '0;
			gather_pos  = 0;
			if (column + 1 >= w) begin
				px.row_end = 1'b1;
				column     = 0;
				pad_left   = (4 - ((w * bpp) & 3)) & 3;
				if (row + 1 >= h) begin
					px.image_end = 1'b1;
					row          = 0;
				end else begin
					row++;
				end
			end else begin
				column++;
			end
			made_one = 1'b1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom.image_width   = 13'd1;
			geom.image_height  = 13'd1;
			geom.pixel_format  = FMT_RGB24;
			geom.bitfield_mode = 1'b0;
			chan_masks         = '0;
			clear_position();
			expected_pixels.delete();
			pixel_number = 0;
			fail_count   = 0;
		end else begin
			if (pix_valid && !pix_stall) begin
				if (expected_pixels.size() == 0) begin
					report_mismatch("pixel arrived with none expected");
				end else begin
					want = expected_pixels.pop_front();
					check_field("red", pix_data.red, want.red);
					check_field("green", pix_data.green, want.green);
					check_field("blue", pix_data.blue, want.blue);
					check_field("alpha", pix_data.alpha, want.alpha);
					check_field("row_end", {7'd0, pix_data.row_end}, {7'd0, want.row_end});
					check_field("image_end", {7'd0, pix_data.image_end},
						{7'd0, want.image_end});
				end
				pixel_number++;
			end
			if (cfg_valid && cfg_ready)
				write_register(cfg_index, cfg_data);
			if (req_valid && !req_stall) begin
				unpack_byte(req_data, made, made_pixel);
				if (made)
					expected_pixels.push_back(made_pixel);
			end
		end
		pending <= expected_pixels.size();
	end

endmodule

>>> verif/bmp_pixel_stream_unpacker_tb.sv
// ----------------------------------------------------------------------------
// bmp_pixel_stream_unpacker_tb
// drives palette writes, register settings and pixel bytes into the unpacker
// in bursts against a receiver that stalls on its own pattern, and leaves
// prediction and comparison to the checker beside the block
// ----------------------------------------------------------------------------
module bmp_pixel_stream_unpacker_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bpu_pkg::*;

	localparam int         RANDOM_ITEMS = 1200;
	localparam int         IDLE_LIMIT   = 1000;
	localparam int         SETTLE       = 8;
	localparam logic [1:0] FMT_SPARE    = 2'd3;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   req_valid = 1'b0;
	logic                   req_stall;
	req_t                   req_data  = '0;
	logic                   pix_valid;
	logic                   pix_stall = 1'b0;
	pix_t                   pix_data;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [31:0]            cfg_data  = '0;
	int                     mismatches;
	int                     outstanding;
	int                     sent_items    = 0;
	int                     burst_left    = 0;
	int                     idle_cycles   = 0;
	bit                     long_hold_due = 1'b0;
	bit                     pal_written [256];
	logic [7:0]             pal_indices [$];
	logic [1:0]             cur_fmt = FMT_RGB24;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	bmp_pixel_stream_unpacker DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix_data  (pix_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	bpu_pixel_checker pixel_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_data   (req_data),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.pix_data   (pix_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (mismatches),
		.pending    (outstanding)
	);

	task automatic send(input req_t r);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		req_valid <= 1'b1;
		req_data  <= r;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
		burst_left--;
		sent_items++;
	endtask

	task automatic send_pixel_byte(input logic [7:0] b);
		req_t r;
		r.func          = FUNC_PIXEL;
		r.palette_index = 8'($urandom_range(0, 255));
		r.palette_word  = $urandom;
		r.data_byte     = b;
		send(r);
	endtask

	task automatic send_palette(input logic [7:0] idx, input logic [31:0] word);
		req_t r;
		r.func          = FUNC_PALETTE;
		r.palette_index = idx;
		r.palette_word  = word;
		r.data_byte     = 8'($urandom_range(0, 255));
		if (!pal_written[idx]) begin
			pal_written[idx] = 1'b1;
			pal_indices.push_back(idx);
		end
		send(r);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
		req_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] with_noise(input logic [31:0] value,
			input logic [31:0] field);
		logic [31:0] upper;
		upper = ($urandom_range(0, 3) == 0) ? $urandom : 32'h0;
		return (upper & ~field) | (value & field);
	endfunction

	function automatic logic [31:0] pick_mask();
		logic [31:0] m;
		case ($urandom_range(0, 3))
			0:       m = MASK_BYTE0;
			1:       m = MASK_BYTE1;
			2:       m = MASK_BYTE2;
			default: m = MASK_BYTE3;
		endcase
		case ($urandom_range(0, 9))
			0:       m = $urandom;
			1:       m = 32'h0;
			2:       m = 32'hFFFF_FFFF;
			3:       m = m ^ (32'h1 << $urandom_range(0, 31));
			default: ;
		endcase
		return m;
	endfunction

	function automatic mask_t random_masks();
		mask_t m;
		m.red_mask   = pick_mask();
		m.green_mask = pick_mask();
		m.blue_mask  = pick_mask();
		m.alpha_mask = pick_mask();
		return m;
	endfunction

	function automatic int image_bytes(input int w, input int h, input logic [1:0] fmt,
			input bit bitf);
		int bpp;
		w = (w < 1) ? 1 : ((w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w);
		h = (h < 1) ? 1 : ((h > MAX_HEIGHT) ? MAX_HEIGHT : h);
		bpp = (fmt == FMT_PAL8) ? 1 : ((bitf || fmt != FMT_RGB24) ? 4 : 3);
		return h * ((w * bpp + 3) / 4 * 4);
	endfunction

	task automatic configure(input int w, input int h, input logic [1:0] fmt,
			input bit bitf, input mask_t masks);
		write_reg(REG_IMAGE_WIDTH, with_noise(32'(w), 32'h1FFF));
		write_reg(REG_IMAGE_HEIGHT, with_noise(32'(h), 32'h1FFF));
		write_reg(REG_PIXEL_FORMAT, with_noise(32'(fmt), 32'h3));
		write_reg(REG_BITFIELD_MODE, with_noise(32'(bitf), 32'h1));
		write_reg(REG_RED_MASK, masks.red_mask);
		write_reg(REG_GREEN_MASK, masks.green_mask);
		write_reg(REG_BLUE_MASK, masks.blue_mask);
		write_reg(REG_ALPHA_MASK, masks.alpha_mask);
		cur_fmt = fmt;
	endtask

	task automatic run_stream(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_palette(8'($urandom_range(0, 255)), $urandom);
			if (cur_fmt == FMT_PAL8)
				send_pixel_byte(pal_indices[$urandom_range(0, pal_indices.size() - 1)]);
			else
				send_pixel_byte(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic image_phase(input int w, input int h, input logic [1:0] fmt,
			input bit bitf, input mask_t masks);
		int total;
		int n;
		configure(w, h, fmt, bitf, masks);
		if (fmt == FMT_PAL8)
			repeat ($urandom_range(1, 4)) send_palette(8'($urandom_range(0, 255)), $urandom);
		total = image_bytes(w, h, fmt, bitf);
		n = (total <= 150) ? total * $urandom_range(1, 3) : $urandom_range(40, 160);
		// trailing partial pixel, cut off by the next register write
		if ($urandom_range(0, 3) == 0)
			n += $urandom_range(1, 3);
		run_stream(n);
	endtask

	// receiver stall pattern
	initial begin
		int mode;
		int len;
		int period;
		wait (arst_n);
		forever begin
			if (long_hold_due) begin
				long_hold_due = 1'b0;
				mode = 3;
			end else begin
				mode = $urandom_range(0, 39);
				mode = (mode == 39) ? 3 : mode % 3;
			end
			len    = (mode == 3) ? $urandom_range(60, 100) : $urandom_range(5, 40);
			period = $urandom_range(2, 5);
			for (int k = 0; k < len && !long_hold_due; k++) begin
				@(negedge clk);
				case (mode)
					0:       pix_stall <= 1'b0;
					1:       pix_stall <= 1'($urandom_range(0, 1));
					2:       pix_stall <= (k % period) == 0;
					default: pix_stall <= 1'b1;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (pix_valid && !pix_stall) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		int         w;
		int         h;
		int         directed_items;
		logic [1:0] fmt;
		mask_t      byte_order;
		byte_order.red_mask   = MASK_BYTE2;
		byte_order.green_mask = MASK_BYTE1;
		byte_order.blue_mask  = MASK_BYTE0;
		byte_order.alpha_mask = MASK_BYTE3;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset geometry: one 24-bit pixel per image, one pad byte per row
		send_pixel_byte(8'hFF);
		send_pixel_byte(8'hFF);
		send_pixel_byte(8'hFF);
		send_pixel_byte(8'hAA);
		send_pixel_byte(8'h00);
		send_pixel_byte(8'h00);
		send_pixel_byte(8'h00);
		send_pixel_byte(8'h55);

		send_palette(8'd0, 32'hFFFF_FFFF);
		send_palette(8'd255, 32'h0000_0000);
		send_palette(8'd128, $urandom);
		send_palette(8'd1, $urandom);

		configure(3, 2, FMT_PAL8, 1'b0, random_masks());
		send_pixel_byte(8'd0);
		send_pixel_byte(8'd255);
		send_pixel_byte(8'd128);
		send_pixel_byte(8'd1);
		send_pixel_byte(8'd255);
		send_pixel_byte(8'd0);
		send_pixel_byte(8'd1);
		send_pixel_byte(8'd0);
		directed_items = sent_items;

		// long receiver hold while bytes keep coming
		configure(MAX_WIDTH_DEF, MAX_HEIGHT, FMT_RGB24, 1'b0, random_masks());
		long_hold_due = 1'b1;
		run_stream(160);
		image_phase(1, 1, FMT_RGB32, 1'b0, random_masks());
		image_phase(0, 0, FMT_RGB24, 1'b0, random_masks());
		image_phase(8191, 8191, FMT_PAL8, 1'b0, random_masks());
		image_phase(3, 2, FMT_SPARE, 1'b0, random_masks());
		image_phase(5, 2, FMT_PAL8, 1'b1, byte_order);
		image_phase(3, 2, FMT_RGB24, 1'b1, byte_order);
		image_phase(2, 3, FMT_RGB32, 1'b1, byte_order);

		while (sent_items < directed_items + RANDOM_ITEMS) begin
			w   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 9);
			h   = $urandom_range(1, 4);
			fmt = ($urandom_range(0, 9) == 0) ? FMT_SPARE : 2'($urandom_range(0, 2));
			image_phase(w, h, fmt, $urandom_range(0, 2) == 0, random_masks());
		end

		req_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> sim.f
design/bpu_pkg.sv
design/bpu_ram.sv
design/bpu_front.sv
design/bpu_queue.sv
design/bpu_back.sv
design/bmp_pixel_stream_unpacker.sv
verif/bpu_pixel_checker.sv
verif/bmp_pixel_stream_unpacker_tb.sv
